// File: hw/rtl/frt_pkg.sv
`default_nettype none

package frt_pkg;

	localparam int SAMPLE_W      = 32;
	localparam int RANK_W        = 8;
	localparam int POS_W         = 6;
	localparam int TALLY_W       = 7;
	localparam int MAX_ITEMS_DEF = 64;

	typedef logic signed [SAMPLE_W-1:0] sample_t;
	typedef logic [RANK_W-1:0]          rank_t;
	typedef logic [POS_W-1:0]           pos_t;

endpackage

`default_nettype wire

// File: hw/rtl/frt_tally.sv
`default_nettype none

module frt_tally (
	input  wire                   clk,
	input  wire                   arst_n,
	input  wire                   clr,
	input  wire                   vld,
	input  wire frt_pkg::sample_t pivot,
	input  wire frt_pkg::sample_t value,
	output frt_pkg::rank_t        rank_doubled
);
	import frt_pkg::*;

	logic [TALLY_W-1:0] smaller_q;
	logic [TALLY_W-1:0] equal_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			smaller_q <= '0;
			equal_q   <= '0;
		end else if (clr) begin
			smaller_q <= '0;
			equal_q   <= '0;
		end else if (vld) begin
			if (value < pivot) begin
				smaller_q <= smaller_q + TALLY_W'(1);
			end else if (value == pivot) begin
				equal_q <= equal_q + TALLY_W'(1);
			end
		end
	end

	assign rank_doubled = RANK_W'({smaller_q, 1'b0}) + RANK_W'(equal_q) + RANK_W'(1);

endmodule

`default_nettype wire

// File: hw/rtl/fractional_rank_transform.sv
`default_nettype none

// Fractional ranking with averaged ties. Samples are collected one per cycle
// while in_stall is low, into a single-port-write, registered-read value
// memory of MAX_ITEMS entries; the sample flagged final_sample closes the set.
// The block then emits one rank per stored sample in arrival order,
// rank_doubled being twice the averaged one-based rank. Samples arriving while
// the memory is full are dropped and every rank of that set carries
// overflowed. Each rank takes one pivot read, N memory reads (for a set of N
// stored samples) streamed through the compare-and-count unit, a pipeline
// drain and the output load. in_stall stays high from the final sample until
// the last rank has been loaded into the output register.

module fractional_rank_transform #(
	parameter int MAX_ITEMS = frt_pkg::MAX_ITEMS_DEF
) (
	input  wire                   clk,
	input  wire                   arst_n,
	input  wire                   in_valid,
	output logic                  in_stall,
	input  wire frt_pkg::sample_t sample,
	input  wire                   final_sample,
	output logic                  out_valid,
	input  wire                   out_stall,
	output frt_pkg::rank_t        rank_doubled,
	output frt_pkg::pos_t         position,
	output logic                  final_rank,
	output logic                  overflowed
);
	import frt_pkg::*;

	localparam int IDX_W = $clog2(MAX_ITEMS);
	localparam int CNT_W = $clog2(MAX_ITEMS + 1);

	typedef enum logic [2:0] {
		ST_COLLECT,
		ST_PIVOT,
		ST_SCAN,
		ST_WAIT,
		ST_RESULT
	} state_t;

	state_t             state_q;
	logic [CNT_W-1:0]   fill_q;
	logic               drop_q;
	logic [IDX_W-1:0]   k_q;
	logic [IDX_W-1:0]   j_q;
	logic               load_pivot_s1;
	logic               cmp_vld_s1;
	logic               cmp_last_s1;
	logic               done_s2;
	sample_t            pivot_q;
	sample_t            rd_data_q;
	sample_t            mem [MAX_ITEMS];

	logic               accept;
	logic               full;
	logic               out_free;
	logic               tally_clr;
	logic               j_last;
	logic               k_last;
	logic [IDX_W-1:0]   rd_addr;
	rank_t              tally_rank;

	assign in_stall = (state_q != ST_COLLECT);
	assign accept   = in_valid && !in_stall;
	assign full     = (fill_q == CNT_W'(MAX_ITEMS));
	assign out_free = !out_valid || !out_stall;
	assign j_last   = (CNT_W'(j_q) + CNT_W'(1) == fill_q);
	assign k_last   = (CNT_W'(k_q) + CNT_W'(1) == fill_q);
	assign rd_addr  = (state_q == ST_PIVOT) ? k_q : j_q;
	assign tally_clr = (state_q == ST_PIVOT);

	always_ff @(posedge clk) begin
		if (accept && !full) begin
			mem[fill_q[IDX_W-1:0]] <= sample;
		end
		rd_data_q <= mem[rd_addr];
		if (load_pivot_s1) begin
			pivot_q <= rd_data_q;
		end
	end

	frt_tally u_tally (
		.clk          (clk),
		.arst_n       (arst_n),
		.clr          (tally_clr),
		.vld          (cmp_vld_s1),
		.pivot        (pivot_q),
		.value        (rd_data_q),
		.rank_doubled (tally_rank)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= ST_COLLECT;
			fill_q        <= '0;
			drop_q        <= 1'b0;
			k_q           <= '0;
			j_q           <= '0;
			load_pivot_s1 <= 1'b0;
			cmp_vld_s1    <= 1'b0;
			cmp_last_s1   <= 1'b0;
			done_s2       <= 1'b0;
			out_valid     <= 1'b0;
			rank_doubled  <= '0;
			position      <= '0;
			final_rank    <= 1'b0;
			overflowed    <= 1'b0;
		end else begin
			load_pivot_s1 <= 1'b0;
			cmp_vld_s1    <= 1'b0;
			cmp_last_s1   <= 1'b0;
			done_s2       <= cmp_vld_s1 && cmp_last_s1;
			if (out_valid && !out_stall && (state_q != ST_RESULT)) begin
				out_valid <= 1'b0;
			end
			unique case (state_q)
				ST_COLLECT: begin
					if (accept) begin
						if (full) begin
							drop_q <= 1'b1;
						end else begin
							fill_q <= fill_q + CNT_W'(1);
						end
						if (final_sample) begin
							k_q     <= '0;
							state_q <= ST_PIVOT;
						end
					end
				end
				ST_PIVOT: begin
					j_q           <= '0;
					load_pivot_s1 <= 1'b1;
					state_q       <= ST_SCAN;
				end
				ST_SCAN: begin
					cmp_vld_s1  <= 1'b1;
					cmp_last_s1 <= j_last;
					if (j_last) begin
						state_q <= ST_WAIT;
					end else begin
						j_q <= j_q + IDX_W'(1);
					end
				end
				ST_WAIT: begin
					if (done_s2) begin
						state_q <= ST_RESULT;
					end
				end
				ST_RESULT: begin
					if (out_free) begin
						out_valid    <= 1'b1;
						rank_doubled <= tally_rank;
						position     <= POS_W'(k_q);
						final_rank   <= k_last;
						overflowed   <= drop_q;
						if (k_last) begin
							fill_q  <= '0;
							drop_q  <= 1'b0;
							state_q <= ST_COLLECT;
						end else begin
							k_q     <= k_q + IDX_W'(1);
							state_q <= ST_PIVOT;
						end
					end else begin
						out_valid <= 1'b1;
					end
				end
				default: begin
					state_q <= ST_COLLECT;
				end
			endcase
		end
	end

endmodule

`default_nettype wire
